// ----- hw/rtl/lapedge_pkg.sv -----
// Shared types, constants and helpers for the Laplacian edge marker.
// No dependencies; the interfaces, the output queue and the top module refer to it by scoped names.
package lapedge_pkg;

	// Largest frame the line memory holds.
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int PIX_W      = 8;
	localparam int THR_W      = 10;
	localparam int CFG_SIZE_W = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);

	// Wide enough for a latched size and for the raw register value.
	localparam int DIM_A = ($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)) ?
		$clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
	localparam int DIM_W = (DIM_A > CFG_SIZE_W) ? DIM_A : CFG_SIZE_W;

	// Signed Laplacian: 4*255 + 4*255 needs PIX_W + 3 bits plus sign.
	localparam int SUM_W = PIX_W + 4;

	// Output queue that absorbs stalls on the result side.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [THR_W-1:0]      RST_THRESHOLD = THR_W'(128);
	localparam logic [CFG_SIZE_W-1:0] RST_WIDTH     = CFG_SIZE_W'(640);
	localparam logic [CFG_SIZE_W-1:0] RST_HEIGHT    = CFG_SIZE_W'(480);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EDGE_THRESHOLD = 2'd0,
		REG_FRAME_WIDTH    = 2'd1,
		REG_FRAME_HEIGHT   = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic edge_flag;
		logic last_in_frame;
	} result_t;

	typedef struct packed {
		logic    valid;
		result_t data;
	} fifo_push_t;

	typedef struct packed {
		logic [FIFO_CNT_W-1:0] count;
	} fifo_status_t;

	// Limits a programmed frame size to 2..hi.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_SIZE_W-1:0] v,
		input logic [DIM_W-1:0] hi);
		logic [DIM_W-1:0] ve;
		ve = DIM_W'(v);
		if (ve < DIM_W'(2)) begin
			return DIM_W'(2);
		end else if (ve > hi) begin
			return hi;
		end
		return ve;
	endfunction

endpackage

// ----- hw/rtl/lapedge_if.sv -----
// Ready/valid channel interfaces for pixel words and result words.
// Depends on lapedge_pkg for field widths.
interface lapedge_pix_if;
	logic                          valid;
	logic                          ready;
	logic [lapedge_pkg::PIX_W-1:0] pixel_value;

	modport source (output valid, output pixel_value, input ready);
	modport sink (input valid, input pixel_value, output ready);
endinterface

interface lapedge_res_if;
	logic valid;
	logic ready;
	logic edge_flag;
	logic last_in_frame;
	logic last_of_run;

	modport source (output valid, output edge_flag, output last_in_frame,
		output last_of_run, input ready);
	modport sink (input valid, input edge_flag, input last_in_frame,
		input last_of_run, output ready);
endinterface

// ----- hw/rtl/lapedge_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lapedge_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/lapedge_out_fifo.sv -----
// Small result queue that drives the result channel and reports its fill level.
// Depends on lapedge_pkg and lapedge_res_if.
module lapedge_out_fifo (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lapedge_pkg::fifo_push_t   push,
	output lapedge_pkg::fifo_status_t status,
	lapedge_res_if.source             results
);

	lapedge_pkg::result_t                  mem_q [lapedge_pkg::FIFO_DEPTH];
	logic [lapedge_pkg::FIFO_PTR_W-1:0]    wptr_q;
	logic [lapedge_pkg::FIFO_PTR_W-1:0]    rptr_q;
	logic [lapedge_pkg::FIFO_CNT_W-1:0]    count_q;
	logic                                  pop;

	assign pop = results.valid && results.ready;

	assign results.valid         = (count_q != '0);
	assign results.edge_flag     = mem_q[rptr_q].edge_flag;
	assign results.last_in_frame = mem_q[rptr_q].last_in_frame;
	// Every pixel causes at most one word, so each word closes its run.
	assign results.last_of_run   = 1'b1;
	assign status.count          = count_q;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wptr_q] <= push.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push.valid) begin
				wptr_q <= (wptr_q == lapedge_pkg::FIFO_PTR_W'(lapedge_pkg::FIFO_DEPTH - 1)) ?
					'0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == lapedge_pkg::FIFO_PTR_W'(lapedge_pkg::FIFO_DEPTH - 1)) ?
					'0 : rptr_q + 1'b1;
			end
			case ({push.valid, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= lapedge_pkg::FIFO_CNT_W'(lapedge_pkg::FIFO_DEPTH))
		else $error("result queue overfilled");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.valid && !pop) |->
		(count_q < lapedge_pkg::FIFO_CNT_W'(lapedge_pkg::FIFO_DEPTH)))
		else $error("push into a full result queue");

	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(push.valid && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count missed a push");

endmodule

// ----- hw/rtl/laplacian_edge_threshold.sv -----
// Four-neighbour Laplacian edge marker over a raster pixel stream, with output queue.
// Depends on lapedge_pkg, lapedge_if, lapedge_ram and lapedge_out_fifo.
//
// Pixels enter one word per clock in raster order; each pixel yields at most one result
// word, the mark for the pixel in the same column one row above, so the output runs one
// row behind and the last row of a frame comes out while the first row of the next frame
// goes in. Both line stores share one 1024 x 16 synchronous RAM: every accepted pixel
// writes its column and reads the next column ahead, so the sustained rate is one pixel
// per clock while the output queue has room. A four-word output queue takes up stalls
// on the result side; pixels are refused only while it has no room.
// Frame size registers are sampled at the first pixel of each frame, the threshold at once.
// The line RAM needs no clearing after reset.
module laplacian_edge_threshold (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lapedge_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lapedge_pkg::CFG_DATA_W-1:0]  cfg_data,
	lapedge_pix_if.sink                         pixels,
	lapedge_res_if.source                       results
);

	localparam int PW = lapedge_pkg::PIX_W;
	localparam int DW = lapedge_pkg::DIM_W;
	localparam int SW = lapedge_pkg::SUM_W;

	localparam logic [DW-1:0] MAXW = DW'(lapedge_pkg::MAX_WIDTH);
	localparam logic [DW-1:0] MAXH = DW'(lapedge_pkg::MAX_HEIGHT);

	// Configuration registers.
	logic [lapedge_pkg::THR_W-1:0]      thr_q;
	logic [lapedge_pkg::CFG_SIZE_W-1:0] width_cfg_q;
	logic [lapedge_pkg::CFG_SIZE_W-1:0] height_cfg_q;

	// Raster position and latched frame size.
	logic [lapedge_pkg::COL_W-1:0] col_q;
	logic [lapedge_pkg::ROW_W-1:0] row_q;
	logic [DW-1:0]                 act_w_q;
	logic [DW-1:0]                 act_h_q;
	logic                          flush_q;
	logic [PW-1:0]                 left_q;

	logic                          accept;
	logic                          first_px;
	logic [DW-1:0]                 w_cur;
	logic [DW-1:0]                 h_cur;
	logic                          last_col;
	logic                          emit;
	logic                          flushing;
	logic [DW-1:0]                 row_inc;

	// RAM word: older row in the upper byte, prior row in the lower byte.
	logic [2*PW-1:0]               rdata;
	logic [2*PW-1:0]               wdata;
	logic [lapedge_pkg::COL_W-1:0] raddr;
	logic [PW-1:0]                 rd_prior;
	logic [PW-1:0]                 rd_older;

	logic          v_s1;
	logic [PW-1:0] centre_s1;
	logic [PW-1:0] up_s1;
	logic [PW-1:0] down_s1;
	logic [PW-1:0] left_s1;
	logic          last_s1;
	logic          lif_s1;

	logic [PW-1:0]            right;
	logic signed [SW-1:0]     sum;
	logic [SW-1:0]            mag;

	lapedge_pkg::fifo_push_t   push;
	lapedge_pkg::fifo_status_t fstat;
	logic [lapedge_pkg::FIFO_CNT_W-1:0] fill;

	assign rd_prior = rdata[PW-1:0];
	assign rd_older = rdata[2*PW-1:PW];

	assign first_px = (row_q == '0) && (col_q == '0);
	assign w_cur    = first_px ? lapedge_pkg::clamp_dim(width_cfg_q, MAXW) : act_w_q;
	assign h_cur    = first_px ? lapedge_pkg::clamp_dim(height_cfg_q, MAXH) : act_h_q;
	assign last_col = (DW'(col_q) == w_cur - 1'b1);
	assign flushing = (row_q == '0);
	assign emit     = !flushing || flush_q;
	assign row_inc  = DW'(row_q) + 1'b1;

	// Room is counted for the word that is still in stage one.
	assign fill         = fstat.count + lapedge_pkg::FIFO_CNT_W'(v_s1);
	assign pixels.ready = (fill < lapedge_pkg::FIFO_CNT_W'(lapedge_pkg::FIFO_DEPTH));
	assign accept       = pixels.valid && pixels.ready;

	// The read for this pixel was issued with the previous pixel, so rdata holds this
	// column's entry. At the row end the look-ahead wraps to column zero for the next row.
	assign wdata = {rd_prior, pixels.pixel_value};
	assign raddr = last_col ? '0 : col_q + 1'b1;

	lapedge_ram #(
		.WIDTH(2 * PW),
		.DEPTH(lapedge_pkg::MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (accept),
		.waddr(col_q),
		.wdata(wdata),
		.re   (accept),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q        <= lapedge_pkg::RST_THRESHOLD;
			width_cfg_q  <= lapedge_pkg::RST_WIDTH;
			height_cfg_q <= lapedge_pkg::RST_HEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lapedge_pkg::REG_EDGE_THRESHOLD: thr_q <= cfg_data[lapedge_pkg::THR_W-1:0];
				lapedge_pkg::REG_FRAME_WIDTH:    width_cfg_q <= cfg_data;
				lapedge_pkg::REG_FRAME_HEIGHT:   height_cfg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			flush_q <= 1'b0;
			act_w_q <= lapedge_pkg::clamp_dim(lapedge_pkg::RST_WIDTH, MAXW);
			act_h_q <= lapedge_pkg::clamp_dim(lapedge_pkg::RST_HEIGHT, MAXH);
			v_s1    <= 1'b0;
		end else begin
			v_s1 <= accept && emit;
			if (accept) begin
				act_w_q <= w_cur;
				act_h_q <= h_cur;
				if (last_col) begin
					col_q <= '0;
					if (row_inc >= h_cur) begin
						row_q   <= '0;
						flush_q <= 1'b1;
					end else begin
						row_q <= row_inc[lapedge_pkg::ROW_W-1:0];
						if (flushing) begin
							flush_q <= 1'b0;
						end
					end
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	// Neighbourhood of the emitted pixel; the right neighbour arrives from the RAM next cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			left_q    <= rd_prior;
			centre_s1 <= rd_prior;
			up_s1     <= (row_q == lapedge_pkg::ROW_W'(1)) ? '0 : rd_older;
			down_s1   <= flushing ? '0 : pixels.pixel_value;
			left_s1   <= (col_q == '0) ? '0 : left_q;
			last_s1   <= last_col;
			lif_s1    <= flushing && last_col;
		end
	end

	assign right = last_s1 ? '0 : rd_prior;
	assign sum   = $signed({2'b00, centre_s1, 2'b00}) - $signed(SW'(up_s1))
		- $signed(SW'(down_s1)) - $signed(SW'(left_s1)) - $signed(SW'(right));
	assign mag   = sum[SW-1] ? SW'(-sum) : SW'(sum);

	assign push.valid              = v_s1;
	assign push.data.edge_flag     = (mag >= SW'(thr_q));
	assign push.data.last_in_frame = lif_s1;

	lapedge_out_fifo u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.status (fstat),
		.results(results)
	);

	a_col_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		DW'(col_q) < act_w_q)
		else $error("column counter beyond the latched width");

	a_flush_first_row: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> (row_q == '0))
		else $error("pending last row outside the first input row");

	a_emit_only_with_row: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && flushing && !flush_q) |=> !v_s1)
		else $error("result word issued with no row to emit");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(fstat.count == '0 && !v_s1) |-> pixels.ready)
		else $error("pixels refused with an empty result path");

endmodule
